// File: rtl/spc_pkg.sv
// shared constants, payload structs and step function of the square panel coupling unit
// no dependencies; every other file of the block refers to it by scoped names
package spc_pkg;

  // fixed-point formats
  localparam int unsigned CoordW = 32;
  localparam int unsigned ValW   = 48;
  localparam int unsigned RootW  = 50;
  localparam int unsigned RemW   = RootW + 2;
  localparam int unsigned RadW   = 2 * RootW;
  localparam int unsigned NumW   = 93;
  localparam int unsigned DivW   = 49;

  // scaled constants
  localparam logic [30:0] KSelf  = 31'd1204952758;   // 2^32 * ln(1+sqrt2) / pi
  localparam logic [28:0] MInv   = 29'd341782638;    // 2^32 / (4 pi)
  localparam logic [33:0] PiQ    = 34'd13493037705;  // 2^32 * pi
  localparam logic [30:0] C282   = 31'd1211180777;   // 2^32 * 0.282
  localparam logic [ValW-1:0] MaxPos = 48'h7FFF_FFFF_FFFF;
  localparam logic [ValW-1:0] MinNeg = 48'h8000_0000_0000;

  // result kind
  typedef enum logic [1:0] {
    CASE_SELF   = 2'd0,
    CASE_CIRCLE = 2'd1,
    CASE_DIST   = 2'd2
  } case_e;

  // register indexes
  typedef enum logic [1:0] {
    REG_SIDE   = 2'd0,
    REG_THRESH = 2'd1,
    REG_MODE   = 2'd2
  } reg_idx_e;

  // radicands of the three root lanes
  typedef struct packed {
    logic [RadW-1:0] r2;
    logic [RadW-1:0] r1;
    logic [RadW-1:0] r0;
  } sq_rad_t;

  // roots: distance, circle outer term, circle inner term
  typedef struct packed {
    logic [RootW-1:0] dq;
    logic [RootW-1:0] a;
    logic [RootW-1:0] b;
  } sq_root_t;

  // per-item data that rides along the root pipeline
  typedef struct packed {
    logic        req;
    logic        zero;
    logic        near;
    logic        neg;
    logic [31:0] self_val;
    logic [59:0] npot;
    logic [NumW-1:0] ssm;
  } sq_side_t;

  // per-item data that rides along the divider pipeline
  typedef struct packed {
    logic        req;
    logic        zero;
    logic        near;
    logic        neg;
    logic [31:0] self_val;
    logic [62:0] cplo;
    logic [48:0] cphi;
  } dv_side_t;

  typedef struct packed {
    logic [RemW-1:0]  rem;
    logic [RootW-1:0] root;
  } sq_step_t;

  // one digit of the restoring square root
  function automatic sq_step_t sqrt_step(input logic [RemW-1:0] rem,
                                         input logic [RootW-1:0] root,
                                         input logic [1:0] pair);
    logic [RemW+1:0] acc;
    logic [RemW+1:0] trial;
    sq_step_t        r;
    acc   = {rem, pair};
    trial = {2'b00, root, 2'b01};
    if (acc >= trial) begin
      r.rem  = RemW'(acc - trial);
      r.root = {root[RootW-2:0], 1'b1};
    end else begin
      r.rem  = acc[RemW-1:0];
      r.root = {root[RootW-2:0], 1'b0};
    end
    return r;
  endfunction

endpackage

// File: rtl/spc_front.sv
// front pipeline: coordinate differences, squares, scaled products, radicands
// depends on spc_pkg
module spc_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  req_type_i,
  input  logic signed [31:0]    own_x_i,
  input  logic signed [31:0]    own_y_i,
  input  logic signed [31:0]    own_z_i,
  input  logic signed [31:0]    other_x_i,
  input  logic signed [31:0]    other_y_i,
  input  logic signed [31:0]    other_z_i,
  input  logic signed [31:0]    charge_i,
  input  logic [31:0]           side_i,
  input  logic [31:0]           thresh_i,
  input  logic                  mode_i,
  output logic                  out_valid_o,
  output spc_pkg::sq_rad_t      rad_o,
  output spc_pkg::sq_side_t     side_o
);

  function automatic logic [31:0] abs_diff(input logic [31:0] a, input logic [31:0] b);
    logic signed [32:0] d;
    d = $signed({a[31], a}) - $signed({b[31], b});
    return d[32] ? 32'(-d) : d[31:0];
  endfunction

  logic [4:0] vld_q;

  // stage 1: absolute differences, charge magnitude
  logic [31:0] dx1_q, dy1_q, dz1_q, mag1_q;
  logic        req1_q, neg1_q;

  always_ff @(posedge clk_i) begin
    dx1_q  <= abs_diff(own_x_i, other_x_i);
    dy1_q  <= abs_diff(own_y_i, other_y_i);
    dz1_q  <= abs_diff(own_z_i, other_z_i);
    mag1_q <= charge_i[31] ? 32'(-charge_i) : 32'(charge_i);
    req1_q <= req_type_i;
    neg1_q <= charge_i[31];
  end

  // stage 2: squares and first products
  logic [63:0] sqx2_q, sqy2_q, sqz2_q, ss2_q, tt2_q;
  logic [62:0] sk2_q;
  logic [59:0] np2_q;
  logic        req2_q, neg2_q;

  always_ff @(posedge clk_i) begin
    sqx2_q <= 64'(dx1_q) * 64'(dx1_q);
    sqy2_q <= 64'(dy1_q) * 64'(dy1_q);
    sqz2_q <= 64'(dz1_q) * 64'(dz1_q);
    ss2_q  <= 64'(side_i) * 64'(side_i);
    tt2_q  <= 64'(thresh_i) * 64'(thresh_i);
    sk2_q  <= 63'(side_i) * 63'(spc_pkg::KSelf);
    np2_q  <= 60'(mag1_q) * 60'(spc_pkg::MInv);
    req2_q <= req1_q;
    neg2_q <= neg1_q;
  end

  // stage 3: squared distance, split side^2 products, rounded self term
  logic [65:0] s3_q;
  logic [60:0] ssl3_q, ssh3_q;
  logic [63:0] ss3_q, tt3_q;
  logic [31:0] self3_q;
  logic [59:0] np3_q;
  logic        req3_q, neg3_q;
  logic [63:0] skr_d;

  assign skr_d = 64'(sk2_q) + 64'h8000_0000;

  always_ff @(posedge clk_i) begin
    s3_q    <= 66'(sqx2_q) + 66'(sqy2_q) + 66'(sqz2_q);
    ssl3_q  <= 61'(ss2_q[31:0]) * 61'(spc_pkg::MInv);
    ssh3_q  <= 61'(ss2_q[63:32]) * 61'(spc_pkg::MInv);
    ss3_q   <= ss2_q;
    tt3_q   <= tt2_q;
    self3_q <= skr_d[63:32];
    np3_q   <= np2_q;
    req3_q  <= req2_q;
    neg3_q  <= neg2_q;
  end

  // stage 4: pi scaled distance parts, far numerator, nearness
  logic [65:0] pl4_q;
  logic [67:0] ph4_q;
  logic [spc_pkg::NumW-1:0] ssm4_q;
  logic [65:0] s4_q;
  logic [63:0] ss4_q;
  logic [31:0] self4_q;
  logic [59:0] np4_q;
  logic        req4_q, neg4_q, zero4_q, near4_q;

  always_ff @(posedge clk_i) begin
    pl4_q   <= 66'(s3_q[31:0]) * 66'(spc_pkg::PiQ);
    ph4_q   <= 68'(s3_q[65:32]) * 68'(spc_pkg::PiQ);
    ssm4_q  <= spc_pkg::NumW'(ssl3_q) + {ssh3_q, 32'b0};
    s4_q    <= s3_q;
    ss4_q   <= ss3_q;
    self4_q <= self3_q;
    np4_q   <= np3_q;
    req4_q  <= req3_q;
    neg4_q  <= neg3_q;
    zero4_q <= (s3_q == '0);
    near4_q <= mode_i & (s3_q <= 66'(tt3_q));
  end

  // stage 5: the three radicands
  logic [spc_pkg::RadW-1:0] ps_d;
  spc_pkg::sq_rad_t  rad_q;
  spc_pkg::sq_side_t side_q;

  assign ps_d = spc_pkg::RadW'(pl4_q) + {ph4_q, 32'b0};

  always_ff @(posedge clk_i) begin
    rad_q.r0        <= {2'b00, s4_q, 32'b0};
    rad_q.r1        <= ps_d + spc_pkg::RadW'({ss4_q, 32'b0});
    rad_q.r2        <= ps_d;
    side_q.req      <= req4_q;
    side_q.zero     <= zero4_q;
    side_q.near     <= near4_q;
    side_q.neg      <= neg4_q;
    side_q.self_val <= self4_q;
    side_q.npot     <= np4_q;
    side_q.ssm      <= ssm4_q;
  end

  // valid bits travel with the stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[3:0], in_valid_i};
    end
  end

  assign out_valid_o = vld_q[4];
  assign rad_o       = rad_q;
  assign side_o      = side_q;

endmodule

// File: rtl/spc_sqrt.sv
// pipelined three-lane integer square root, one root bit per stage
// depends on spc_pkg
module spc_sqrt (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  spc_pkg::sq_rad_t  rad_i,
  input  spc_pkg::sq_side_t side_i,
  output logic              out_valid_o,
  output spc_pkg::sq_root_t root_o,
  output spc_pkg::sq_side_t side_o
);

  localparam int unsigned Stages = spc_pkg::RootW;

  logic [Stages-1:0]                      vld_q;
  logic [2:0][spc_pkg::RemW-1:0]          rem_q  [Stages];
  logic [2:0][spc_pkg::RootW-1:0]         rt_q   [Stages];
  logic [2:0][spc_pkg::RadW-1:0]          rd_q   [Stages];
  spc_pkg::sq_side_t                      sd_q   [Stages];

  for (genvar g = 0; g < Stages; g++) begin : g_stage
    logic                               vin;
    logic [2:0][spc_pkg::RemW-1:0]      rem_in, rem_d;
    logic [2:0][spc_pkg::RootW-1:0]     rt_in, rt_d;
    logic [2:0][spc_pkg::RadW-1:0]      rd_in, rd_d;
    spc_pkg::sq_side_t                  sd_in;

    if (g == 0) begin : g_first
      assign vin    = in_valid_i;
      assign rem_in = '0;
      assign rt_in  = '0;
      assign rd_in  = {rad_i.r2, rad_i.r1, rad_i.r0};
      assign sd_in  = side_i;
    end else begin : g_next
      assign vin    = vld_q[g-1];
      assign rem_in = rem_q[g-1];
      assign rt_in  = rt_q[g-1];
      assign rd_in  = rd_q[g-1];
      assign sd_in  = sd_q[g-1];
    end

    // one digit on each lane
    always_comb begin
      spc_pkg::sq_step_t st;
      for (int l = 0; l < 3; l++) begin
        st       = spc_pkg::sqrt_step(rem_in[l], rt_in[l],
                                      rd_in[l][spc_pkg::RadW-1:spc_pkg::RadW-2]);
        rem_d[l] = st.rem;
        rt_d[l]  = st.root;
        rd_d[l]  = {rd_in[l][spc_pkg::RadW-3:0], 2'b00};
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[g] <= rem_d;
      rt_q[g]  <= rt_d;
      rd_q[g]  <= rd_d;
      sd_q[g]  <= sd_in;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[g] <= 1'b0;
      end else begin
        vld_q[g] <= vin;
      end
    end
  end

  assign out_valid_o = vld_q[Stages-1];
  assign root_o.dq   = rt_q[Stages-1][0];
  assign root_o.a    = rt_q[Stages-1][1];
  assign root_o.b    = rt_q[Stages-1][2];
  assign side_o      = sd_q[Stages-1];

endmodule

// File: rtl/spc_div.sv
// pipelined restoring divider, one quotient bit per stage
// depends on spc_pkg
module spc_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  input  logic [spc_pkg::NumW-1:0]  num_i,
  input  logic [spc_pkg::DivW-1:0]  den_i,
  input  spc_pkg::dv_side_t         side_i,
  output logic                      out_valid_o,
  output logic [spc_pkg::NumW-1:0]  quo_o,
  output spc_pkg::dv_side_t         side_o
);

  localparam int unsigned Stages = spc_pkg::NumW;

  logic [Stages-1:0]          vld_q;
  logic [spc_pkg::DivW-1:0]   rem_q [Stages];
  logic [spc_pkg::NumW-1:0]   nq_q  [Stages];   // numerator bits out, quotient bits in
  logic [spc_pkg::DivW-1:0]   den_q [Stages];
  spc_pkg::dv_side_t          sd_q  [Stages];

  for (genvar g = 0; g < Stages; g++) begin : g_stage
    logic                       vin;
    logic [spc_pkg::DivW-1:0]   rem_in, den_in, rem_d;
    logic [spc_pkg::NumW-1:0]   nq_in, nq_d;
    spc_pkg::dv_side_t          sd_in;
    logic [spc_pkg::DivW:0]     acc;
    logic                       ge;

    if (g == 0) begin : g_first
      assign vin    = in_valid_i;
      assign rem_in = '0;
      assign nq_in  = num_i;
      assign den_in = den_i;
      assign sd_in  = side_i;
    end else begin : g_next
      assign vin    = vld_q[g-1];
      assign rem_in = rem_q[g-1];
      assign nq_in  = nq_q[g-1];
      assign den_in = den_q[g-1];
      assign sd_in  = sd_q[g-1];
    end

    // shift in the next numerator bit, subtract when it fits
    assign acc   = {rem_in, nq_in[spc_pkg::NumW-1]};
    assign ge    = (acc >= {1'b0, den_in});
    assign rem_d = ge ? spc_pkg::DivW'(acc - {1'b0, den_in}) : acc[spc_pkg::DivW-1:0];
    assign nq_d  = {nq_in[spc_pkg::NumW-2:0], ge};

    always_ff @(posedge clk_i) begin
      rem_q[g] <= rem_d;
      nq_q[g]  <= nq_d;
      den_q[g] <= den_in;
      sd_q[g]  <= sd_in;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[g] <= 1'b0;
      end else begin
        vld_q[g] <= vin;
      end
    end
  end

  assign out_valid_o = vld_q[Stages-1];
  assign quo_o       = nq_q[Stages-1];
  assign side_o      = sd_q[Stages-1];

endmodule

// File: rtl/square_panel_coupling_unit.sv
// top level of the square panel coupling unit: config registers, operand select, output format
// depends on spc_pkg, spc_front, spc_sqrt and spc_div
//
//  channel   direction  handshake                 payload
//  request   in         start_i, busy_o           req_type_i, own_*_i, other_*_i, charge_i
//  config    in         cfg_valid_i, cfg_ready_o  cfg_index_i, cfg_data_i
//  result    out        result_valid_o strobe     scaled_value_o, case_used_o, saturated_o
//
// one request per cycle; between the accepting edge and the result strobe lie the root
// pipeline (50 stages, one root bit each), the divider pipeline (93 stages, one quotient
// bit each) and eight stages of setup and format
// busy_o stays low and cfg_ready_o high; the result side has no backpressure
// reset clears the valid bits and loads the register defaults
module square_panel_coupling_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  input  logic                req_type_i,
  input  logic signed [31:0]  own_x_i,
  input  logic signed [31:0]  own_y_i,
  input  logic signed [31:0]  own_z_i,
  input  logic signed [31:0]  other_x_i,
  input  logic signed [31:0]  other_y_i,
  input  logic signed [31:0]  other_z_i,
  input  logic signed [31:0]  charge_i,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [1:0]          cfg_index_i,
  input  logic [31:0]         cfg_data_i,
  output logic                result_valid_o,
  output logic signed [47:0]  scaled_value_o,
  output logic [1:0]          case_used_o,
  output logic                saturated_o
);

  typedef struct packed {
    logic                     req;
    logic                     neg;
    spc_pkg::case_e           cs;
    logic [31:0]              self_val;
    logic [spc_pkg::NumW-1:0] quo;
    logic [77:0]              far;
    logic [33:0]              circ;
  } fin_t;

  // config registers
  logic [31:0] side_q, thresh_q;
  logic        mode_q;
  logic        cfg_we;

  assign cfg_ready_o = 1'b1;
  assign busy_o      = 1'b0;
  assign cfg_we      = cfg_valid_i & cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_q   <= 32'd0;
      thresh_q <= 32'd838861;
      mode_q   <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index_i)
        spc_pkg::REG_SIDE:   side_q   <= cfg_data_i;
        spc_pkg::REG_THRESH: thresh_q <= cfg_data_i;
        spc_pkg::REG_MODE:   mode_q   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // front stages
  logic              fr_valid;
  spc_pkg::sq_rad_t  fr_rad;
  spc_pkg::sq_side_t fr_side;

  spc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (start_i & ~busy_o),
    .req_type_i  (req_type_i),
    .own_x_i     (own_x_i),
    .own_y_i     (own_y_i),
    .own_z_i     (own_z_i),
    .other_x_i   (other_x_i),
    .other_y_i   (other_y_i),
    .other_z_i   (other_z_i),
    .charge_i    (charge_i),
    .side_i      (side_q),
    .thresh_i    (thresh_q),
    .mode_i      (mode_q),
    .out_valid_o (fr_valid),
    .rad_o       (fr_rad),
    .side_o      (fr_side)
  );

  // root pipeline
  logic              sq_valid;
  spc_pkg::sq_root_t sq_root;
  spc_pkg::sq_side_t sq_side;

  spc_sqrt u_sqrt (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (fr_valid),
    .rad_i       (fr_rad),
    .side_i      (fr_side),
    .out_valid_o (sq_valid),
    .root_o      (sq_root),
    .side_o      (sq_side)
  );

  // operand select for the divider, circle term partial products
  logic [spc_pkg::RootW-1:0] dlt_d;
  logic [68:0]               pnum_d;
  logic                      m_valid_q;
  logic [spc_pkg::NumW-1:0]  m_num_q;
  logic [spc_pkg::DivW-1:0]  m_den_q;
  spc_pkg::dv_side_t         m_side_q;

  assign dlt_d  = sq_root.a - sq_root.b;
  assign pnum_d = 69'({sq_side.npot, 8'b0}) + 69'(sq_root.dq[spc_pkg::RootW-1:1]);

  always_ff @(posedge clk_i) begin
    m_num_q           <= sq_side.req ? spc_pkg::NumW'(pnum_d) : sq_side.ssm;
    m_den_q           <= sq_root.dq[spc_pkg::DivW-1:0];
    m_side_q.req      <= sq_side.req;
    m_side_q.zero     <= sq_side.zero;
    m_side_q.near     <= sq_side.near;
    m_side_q.neg      <= sq_side.neg;
    m_side_q.self_val <= sq_side.self_val;
    m_side_q.cplo     <= 63'(dlt_d[31:0]) * 63'(spc_pkg::C282);
    m_side_q.cphi     <= 49'(dlt_d[spc_pkg::RootW-1:32]) * 49'(spc_pkg::C282);
  end

  // divider pipeline
  logic                     dv_valid;
  logic [spc_pkg::NumW-1:0] dv_quo;
  spc_pkg::dv_side_t        dv_side;

  spc_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (m_valid_q),
    .num_i       (m_num_q),
    .den_i       (m_den_q),
    .side_i      (m_side_q),
    .out_valid_o (dv_valid),
    .quo_o       (dv_quo),
    .side_o      (dv_side)
  );

  // rounding of far and circle terms, result kind
  fin_t        e1_d, e1_q;
  logic        e1_valid_q;
  logic [93:0] farsum_d;
  logic [81:0] circsum_d;

  assign farsum_d  = 94'(dv_quo) + 94'h8000;
  assign circsum_d = 82'(dv_side.cplo) + 82'({dv_side.cphi, 32'b0}) + (82'd1 << 47);

  always_comb begin
    e1_d.req      = dv_side.req;
    e1_d.neg      = dv_side.neg;
    e1_d.self_val = dv_side.self_val;
    e1_d.quo      = dv_quo;
    e1_d.far      = farsum_d[93:16];
    e1_d.circ     = circsum_d[81:48];
    if (dv_side.zero) begin
      e1_d.cs = spc_pkg::CASE_SELF;
    end else if (dv_side.req) begin
      e1_d.cs = spc_pkg::CASE_DIST;
    end else if (dv_side.near) begin
      e1_d.cs = spc_pkg::CASE_CIRCLE;
    end else begin
      e1_d.cs = spc_pkg::CASE_DIST;
    end
  end

  always_ff @(posedge clk_i) begin
    e1_q <= e1_d;
  end

  // final select and saturation
  logic [47:0] val_d, val_q;
  logic        sat_d, sat_q;
  logic [1:0]  cs_q;
  logic        out_valid_q;

  always_comb begin
    val_d = '0;
    sat_d = 1'b0;
    case (e1_q.cs)
      spc_pkg::CASE_SELF: begin
        val_d = e1_q.req ? 48'd0 : 48'(e1_q.self_val);
      end
      spc_pkg::CASE_CIRCLE: begin
        val_d = 48'(e1_q.circ);
      end
      spc_pkg::CASE_DIST: begin
        if (e1_q.req && e1_q.neg) begin
          if (e1_q.quo > spc_pkg::NumW'(spc_pkg::MinNeg)) begin
            val_d = spc_pkg::MinNeg;
            sat_d = 1'b1;
          end else begin
            val_d = 48'd0 - e1_q.quo[47:0];
          end
        end else if (e1_q.req) begin
          if (e1_q.quo > spc_pkg::NumW'(spc_pkg::MaxPos)) begin
            val_d = spc_pkg::MaxPos;
            sat_d = 1'b1;
          end else begin
            val_d = e1_q.quo[47:0];
          end
        end else begin
          if (e1_q.far > 78'(spc_pkg::MaxPos)) begin
            val_d = spc_pkg::MaxPos;
            sat_d = 1'b1;
          end else begin
            val_d = e1_q.far[47:0];
          end
        end
      end
      default: begin
        val_d = '0;
        sat_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
    sat_q <= sat_d;
    cs_q  <= e1_q.cs;
  end

  // valid bits of the local stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q   <= 1'b0;
      e1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      m_valid_q   <= sq_valid;
      e1_valid_q  <= dv_valid;
      out_valid_q <= e1_valid_q;
    end
  end

  assign result_valid_o = out_valid_q;
  assign scaled_value_o = $signed(val_q);
  assign case_used_o    = cs_q;
  assign saturated_o    = sat_q;

  // only the distance term can clip
  a_sat_dist: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && saturated_o) |-> (case_used_o == spc_pkg::CASE_DIST))
    else $error("saturation outside distance term");

  // circle approximation is never negative
  a_circ_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && case_used_o == spc_pkg::CASE_CIRCLE) |-> !scaled_value_o[47])
    else $error("negative circle term");

  // self term and zero potential are never negative
  a_self_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && case_used_o == spc_pkg::CASE_SELF) |-> !scaled_value_o[47])
    else $error("negative self term");

  // a result strobe follows a finished division, registered through e1 and the output stage
  a_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dv_valid |=> ##1 result_valid_o)
    else $error("division result lost before output");

endmodule
